// ===== src/aabb_collide_impulse_resolve_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box collision resolver
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLIDE_IMPULSE_RESOLVE_MACROS_SVH
`define AABB_COLLIDE_IMPULSE_RESOLVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACI_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// The condition must never be true.
`define ACI_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== src/aci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_pkg
// Types and constants shared by the box collision resolver modules.
// ----------------------------------------------------------------------------
package aci_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int COORD_MAX      = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [16:0] BOUNCE_ONE = 17'h10000;

  localparam logic [1:0] NORMAL_PX = 2'd0;
  localparam logic [1:0] NORMAL_NX = 2'd1;
  localparam logic [1:0] NORMAL_PY = 2'd2;
  localparam logic [1:0] NORMAL_NY = 2'd3;

  typedef struct packed {
    logic [63:0] a_position;
    logic [63:0] a_half_size;
    logic [63:0] a_velocity;
    logic [31:0] a_mass;
    logic [16:0] a_bounce;
    logic [63:0] b_position;
    logic [63:0] b_half_size;
    logic [63:0] b_velocity;
    logic [31:0] b_mass;
    logic [16:0] b_bounce;
  } item_t;

  typedef struct packed {
    logic               overlap;
    logic [1:0]         normal_code;
    logic signed [31:0] penetration;
    logic               impulse_applied;
    logic               both_immovable;
    logic [63:0]        a_velocity_out;
    logic [63:0]        b_velocity_out;
  } result_t;

  typedef struct packed {
    logic               overlap;
    logic [1:0]         normal_code;
    logic signed [31:0] penetration;
    logic               impulse;
    logic               both;
    logic               xaxis;
    logic               neg;
    logic [COORD_MAX:0] mag;
    logic [16:0]        bounce;
    logic [31:0]        na;
    logic [31:0]        nb;
    logic [32:0]        den;
    logic [63:0]        a_velocity;
    logic [63:0]        b_velocity;
  } cls_t;

endpackage

// ===== src/aci_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_front
// Overlap test, contact axis and normal, approach speed and mass weights.
// ----------------------------------------------------------------------------
module aci_front #(
  parameter int COORD_BITS = aci_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  aci_pkg::item_t item,
  output logic           out_vld,
  output aci_pkg::cls_t  out_cls
);
  import aci_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int GB = C + 3;
  localparam logic signed [GB-1:0] PEN_MIN = {{(GB-C+1){1'b1}}, {(C-1){1'b0}}};

  logic signed [C-1:0]  pax, pay, pbx, pby, hax, hay, hbx, hby, vax, vay, vbx, vby;
  logic signed [GB-1:0] dx, dy, adx, ady, gx, gy, d_sel, pen_sel, pen_c, dv, van, magv;
  logic signed [C-1:0]  pen_n;
  logic                 ov, xaxis, dpos, approach, ma_z, mb_z;
  logic [16:0]          ea, eb;
  cls_t                 cls_next;

  assign pax = item.a_position[C-1:0];
  assign pay = item.a_position[32 +: C];
  assign pbx = item.b_position[C-1:0];
  assign pby = item.b_position[32 +: C];
  assign hax = item.a_half_size[C-1:0];
  assign hay = item.a_half_size[32 +: C];
  assign hbx = item.b_half_size[C-1:0];
  assign hby = item.b_half_size[32 +: C];
  assign vax = item.a_velocity[C-1:0];
  assign vay = item.a_velocity[32 +: C];
  assign vbx = item.b_velocity[C-1:0];
  assign vby = item.b_velocity[32 +: C];

  always_comb begin
    dx       = GB'(pbx) - GB'(pax);
    dy       = GB'(pby) - GB'(pay);
    adx      = dx[GB-1] ? -dx : dx;
    ady      = dy[GB-1] ? -dy : dy;
    gx       = adx - (GB'(hax) + GB'(hbx));
    gy       = ady - (GB'(hay) + GB'(hby));
    ov       = gx[GB-1] && gy[GB-1];
    xaxis    = gx > gy;
    d_sel    = xaxis ? dx : dy;
    dpos     = !d_sel[GB-1] && (d_sel != '0);
    pen_sel  = xaxis ? gx : gy;
    pen_c    = (pen_sel < PEN_MIN) ? PEN_MIN : pen_sel;
    pen_n    = pen_c[C-1:0];
    dv       = xaxis ? (GB'(vbx) - GB'(vax)) : (GB'(vby) - GB'(vay));
    van      = dpos ? dv : -dv;
    approach = van[GB-1] || (van == '0);
    magv     = -van;
    ma_z     = (item.a_mass == '0);
    mb_z     = (item.b_mass == '0);
    ea       = (item.a_bounce > BOUNCE_ONE) ? BOUNCE_ONE : item.a_bounce;
    eb       = (item.b_bounce > BOUNCE_ONE) ? BOUNCE_ONE : item.b_bounce;

    cls_next.overlap     = ov;
    cls_next.penetration = ov ? 32'(pen_n) : '0;
    if (!ov) begin
      cls_next.normal_code = NORMAL_PX;
    end else if (xaxis) begin
      cls_next.normal_code = dpos ? NORMAL_PX : NORMAL_NX;
    end else begin
      cls_next.normal_code = dpos ? NORMAL_PY : NORMAL_NY;
    end
    cls_next.impulse    = ov && approach && !(ma_z && mb_z);
    cls_next.both       = ov && approach && ma_z && mb_z;
    cls_next.xaxis      = xaxis;
    cls_next.neg        = !dpos;
    cls_next.mag        = (COORD_MAX+1)'(magv[C:0]);
    cls_next.bounce     = (eb < ea) ? eb : ea;
    if (mb_z) begin
      cls_next.na  = 32'd1;
      cls_next.nb  = '0;
      cls_next.den = 33'd1;
    end else if (ma_z) begin
      cls_next.na  = '0;
      cls_next.nb  = 32'd1;
      cls_next.den = 33'd1;
    end else begin
      cls_next.na  = item.b_mass;
      cls_next.nb  = item.a_mass;
      cls_next.den = 33'(item.a_mass) + 33'(item.b_mass);
    end
    cls_next.a_velocity = item.a_velocity;
    cls_next.b_velocity = item.b_velocity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_cls <= cls_next;
    end
  end

endmodule

// ===== src/aci_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_queue
// Short first-in first-out queue between the classifier and the resolver.
// ----------------------------------------------------------------------------
module aci_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  aci_pkg::cls_t push_data,
  input  logic          pop,
  output aci_pkg::cls_t pop_data,
  output logic          not_empty,
  output logic          full
);
  import aci_pkg::*;

  localparam int PB = $clog2(QUEUE_DEPTH);
  localparam int CB = $clog2(QUEUE_DEPTH + 1);

  cls_t          entries [QUEUE_DEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [CB-1:0] count;
  logic          do_push, do_pop;

  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign not_empty = (count != '0);
  assign full      = (count == CB'(QUEUE_DEPTH));
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PB'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PB'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CB'(do_push) - CB'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/aci_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_div
// Pipelined restoring divider, one quotient bit per stage, rounded half up.
// ----------------------------------------------------------------------------
module aci_div #(
  parameter int NB = 83,
  parameter int DB = 49,
  parameter int QB = 34
) (
  input  logic          clk,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic [QB-1:0] quo
);

  logic [DB-1:0] rem  [QB+1];
  logic [QB-1:0] low  [QB+1];
  logic [DB-1:0] dv   [QB+1];
  logic [QB-1:0] qacc [QB+1];

  assign rem[0]  = DB'(num >> QB);
  assign low[0]  = num[QB-1:0];
  assign dv[0]   = den;
  assign qacc[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DB:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem[i], low[i][QB-1]};
      ge    = trial >= {1'b0, dv[i]};
    end

    always_ff @(posedge clk) begin
      rem[i+1]  <= ge ? DB'(trial - {1'b0, dv[i]}) : DB'(trial);
      low[i+1]  <= low[i] << 1;
      dv[i+1]   <= dv[i];
      qacc[i+1] <= {qacc[i][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    quo <= qacc[QB] + QB'({rem[QB], 1'b0} >= {1'b0, dv[QB]});
  end

endmodule

// ===== src/aci_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_back
// Impulse resolver: impulse size, mass split by division, velocity update.
// ----------------------------------------------------------------------------
module aci_back #(
  parameter int COORD_BITS = aci_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  aci_pkg::cls_t    in_cls,
  output logic             done,
  output aci_pkg::result_t result
);
  import aci_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int KB  = C + 19;
  localparam int NB  = KB + 32;
  localparam int QB  = C + 2;
  localparam int DB  = 49;
  localparam int LAT = QB + 4;
  localparam int UB  = C + 3;
  localparam logic signed [UB-1:0] VMAX = {{(UB-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [UB-1:0] VMIN = {{(UB-C+1){1'b1}}, {(C-1){1'b0}}};

  logic              vld [LAT];
  cls_t              cq  [LAT];
  logic [17:0]       kf;
  logic [KB-1:0]     k;
  logic [63:0]       pa_lo, pb_lo;
  logic [KB-1:0]     pa_hi, pb_hi;
  logic [NB-1:0]     num_a, num_b;
  logic [DB-1:0]     dfull;
  logic [QB-1:0]     qa, qb;
  cls_t              cl;
  logic signed [C-1:0]  vax, vay, vbx, vby;
  logic signed [UB-1:0] dqa, dqb, av_sel, bv_sel, av_new, bv_new;
  logic signed [UB-1:0] ax_o, ay_o, bx_o, by_o;
  result_t           res_next;

  function automatic logic [31:0] sat32(input logic signed [UB-1:0] v);
    logic signed [UB-1:0] t;
    logic signed [C-1:0]  n;
    t = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    n = t[C-1:0];
    return 32'(n);
  endfunction

  assign kf    = 18'(BOUNCE_ONE) + 18'(in_cls.bounce);
  assign dfull = {cq[2].den, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= in_vld;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cq[0] <= in_cls;
    for (int i = 1; i < LAT; i++) begin
      cq[i] <= cq[i-1];
    end
    k     <= KB'(kf) * KB'(in_cls.mag[C:0]);
    pa_lo <= 64'(k[31:0]) * 64'(cq[0].na);
    pb_lo <= 64'(k[31:0]) * 64'(cq[0].nb);
    pa_hi <= KB'(k[KB-1:32]) * KB'(cq[0].na);
    pb_hi <= KB'(k[KB-1:32]) * KB'(cq[0].nb);
    num_a <= NB'(pa_lo) + (NB'(pa_hi) << 32);
    num_b <= NB'(pb_lo) + (NB'(pb_hi) << 32);
  end

  aci_div #(.NB(NB), .DB(DB), .QB(QB)) u_div_a (
    .clk (clk),
    .num (num_a),
    .den (dfull),
    .quo (qa)
  );

  aci_div #(.NB(NB), .DB(DB), .QB(QB)) u_div_b (
    .clk (clk),
    .num (num_b),
    .den (dfull),
    .quo (qb)
  );

  always_comb begin
    cl     = cq[LAT-1];
    vax    = cl.a_velocity[C-1:0];
    vay    = cl.a_velocity[32 +: C];
    vbx    = cl.b_velocity[C-1:0];
    vby    = cl.b_velocity[32 +: C];
    dqa    = signed'(UB'(qa));
    dqb    = signed'(UB'(qb));
    av_sel = cl.xaxis ? UB'(vax) : UB'(vay);
    bv_sel = cl.xaxis ? UB'(vbx) : UB'(vby);
    av_new = cl.neg ? av_sel + dqa : av_sel - dqa;
    bv_new = cl.neg ? bv_sel - dqb : bv_sel + dqb;
    ax_o   = (cl.impulse && cl.xaxis)  ? av_new : UB'(vax);
    ay_o   = (cl.impulse && !cl.xaxis) ? av_new : UB'(vay);
    bx_o   = (cl.impulse && cl.xaxis)  ? bv_new : UB'(vbx);
    by_o   = (cl.impulse && !cl.xaxis) ? bv_new : UB'(vby);

    res_next.overlap         = cl.overlap;
    res_next.normal_code     = cl.normal_code;
    res_next.penetration     = cl.penetration;
    res_next.impulse_applied = cl.impulse;
    res_next.both_immovable  = cl.both;
    res_next.a_velocity_out  = {sat32(ay_o), sat32(ax_o)};
    res_next.b_velocity_out  = {sat32(by_o), sat32(bx_o)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

// ===== src/aabb_collide_impulse_resolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_collide_impulse_resolve
// Collision test and restitution impulse for one pair of 2D boxes.
// ----------------------------------------------------------------------------
// A pair is transferred in on a rising edge where start is high and busy is
// low; item carries both bodies. One result per pair appears on result for
// exactly one cycle, marked by done, in the order the pairs came in.
// The receiver cannot stall, so results are never held back.
// The division of the impulse by the summed masses runs one quotient bit per
// pipeline stage, and that divider pipeline sets the latency. A new pair may
// be transferred every cycle while busy is low.
// The classifier and the resolver are joined by a two-entry queue; the
// resolver drains it every cycle, so busy stays low in normal operation.
// Synchronous reset empties the queue and the pipeline valid bits; no result
// is produced for a pair in flight at reset. Busy is high while rst is high.
// ----------------------------------------------------------------------------
module aabb_collide_impulse_resolve #(
  parameter int COORD_BITS = aci_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  aci_pkg::item_t   item,
  output logic             done,
  output aci_pkg::result_t result
);
  import aci_pkg::*;

  logic accept;
  logic front_vld;
  cls_t front_cls;
  cls_t queue_cls;
  logic queue_ne;
  logic queue_full;

  assign busy   = queue_full || rst;
  assign accept = start && !busy;

  aci_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .out_vld (front_vld),
    .out_cls (front_cls)
  );

  aci_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_vld),
    .push_data (front_cls),
    .pop       (queue_ne),
    .pop_data  (queue_cls),
    .not_empty (queue_ne),
    .full      (queue_full)
  );

  aci_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .in_vld (queue_ne),
    .in_cls (queue_cls),
    .done   (done),
    .result (result)
  );

endmodule

// ===== src/aci_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_checker
// Port-level checks on the reported contact and flags of each result.
// ----------------------------------------------------------------------------
`include "aabb_collide_impulse_resolve_macros.svh"

module aci_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input aci_pkg::result_t result,
  input logic             done
);
  import aci_pkg::*;

  logic no_contact_ok;
  logic start_seen;

  assign no_contact_ok = (result.normal_code == NORMAL_PX) && (result.penetration == '0) &&
                         !result.impulse_applied && !result.both_immovable;
  assign start_seen    = start || busy;

  `ACI_CHECK(a_impulse_needs_overlap, done && result.impulse_applied, result.overlap)
  `ACI_CHECK(a_flags_exclusive, done && start_seen, !(result.impulse_applied && result.both_immovable))
  `ACI_CHECK(a_no_contact_report, done && !result.overlap, no_contact_ok)
  `ACI_NEVER(a_positive_penetration, done && !result.penetration[31] && (result.penetration != '0))

endmodule

bind aabb_collide_impulse_resolve aci_checker u_aci_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .done   (done)
);
